// File: hw/rtl/hjkd_pkg.sv
// ----------------------------------------------------------------------------
// Headset jack and key detector package
// Shared widths, register indexes and the result word layout.
// ----------------------------------------------------------------------------
package hjkd_pkg;

  localparam int ADC_W      = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_THRESHOLD     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLASSIFY_INTERVAL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLASSIFY_POLLS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_START_DELAY   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_POLL_INTERVAL = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_CONFIRM_TICKS = 3'd6;

  localparam logic [1:0] KIND_NONE      = 2'd0;
  localparam logic [1:0] KIND_HEADSET   = 2'd1;
  localparam logic [1:0] KIND_HEADPHONE = 2'd2;

  typedef struct packed {
    logic       key_updated;
    logic       jack_updated;
    logic       key_down;
    logic [1:0] jack_kind;
  } result_t;

endpackage

// File: hw/rtl/headset_jack_and_key_detector.sv
// ----------------------------------------------------------------------------
// Headset jack and key detector
// Debounces the jack pin, classifies headset or headphone, reports the key.
// ----------------------------------------------------------------------------
// Each word on the slave stream is one tick of the detector clock. It carries
// the jack pin level (low means a plug is in), the mic bias flag and an ADC
// sample of the mic line. Every tick yields exactly one word on the master
// stream with the current jack kind, the key state and two update flags.
// Settings are written through the cfg channel, which is always ready; they
// are meant to change only while no tick is in flight.
// A word is accepted in every cycle in which the queue has a free entry; its result
// is registered into the queue on acceptance. The tick logic is a single pass from
// the accepted word and the state registers into a two-entry result queue, which
// sets the throughput of one word per cycle while the queue is not full.
// When the master side stalls, the queue holds up to two results and s_tready
// drops only when both entries are full. Reset empties the queue, restores
// the default settings and starts a debounce wait with no jack reported.
// ----------------------------------------------------------------------------
module headset_jack_and_key_detector #(
  parameter int ADC_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [0] jack_level, [1] mic_bias_on, [13:2] adc_level, [15:14] zero
  input  logic [hjkd_pkg::IN_DATA_W-1:0]      s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [1:0] jack_kind, [2] key_down, [3] jack_updated, [4] key_updated, [7:5] zero
  output logic [hjkd_pkg::OUT_DATA_W-1:0]     m_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [hjkd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hjkd_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import hjkd_pkg::*;

  logic    tick_accept;
  result_t tick_result;
  result_t head_result;

  assign tick_accept = s_tvalid && s_tready;
  assign cfg_ready   = 1'b1;

  hjkd_core #(
    .ADC_BITS(ADC_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .tick_valid  (tick_accept),
    .jack_level  (s_tdata[0]),
    .mic_bias_on (s_tdata[1]),
    .adc_level   (s_tdata[ADC_W+1:2]),
    .cfg_valid   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .result      (tick_result)
  );

  hjkd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (tick_accept),
    .push_data (tick_result),
    .can_push  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (head_result)
  );

  assign m_tdata = {(OUT_DATA_W - $bits(result_t))'(0), head_result};

endmodule

// File: hw/rtl/hjkd_core.sv
// ----------------------------------------------------------------------------
// Headset jack and key detector core
// Holds the settings and the detection state and works out one tick's result.
// ----------------------------------------------------------------------------
module hjkd_core #(
  parameter int ADC_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              tick_valid,
  input  logic                              jack_level,
  input  logic                              mic_bias_on,
  input  logic [hjkd_pkg::ADC_W-1:0]        adc_level,
  input  logic                              cfg_valid,
  input  logic [hjkd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hjkd_pkg::CFG_DATA_W-1:0]   cfg_data,
  output hjkd_pkg::result_t                 result
);
  import hjkd_pkg::*;

  localparam int USE_BITS = (ADC_BITS < ADC_W) ? ADC_BITS : ADC_W;

  typedef enum logic [1:0] {JP_WAIT, JP_SETTLE, JP_CLASSIFY, JP_IDLE} jack_phase_t;
  typedef enum logic [1:0] {KP_IDLE, KP_START, KP_PENDING, KP_RUN} key_phase_t;

  logic [11:0] key_threshold;
  logic [9:0]  debounce_ticks;
  logic [7:0]  classify_interval;
  logic [5:0]  classify_polls;
  logic [9:0]  key_start_delay;
  logic [9:0]  key_poll_interval;
  logic [7:0]  key_confirm_ticks;

  jack_phase_t jack_phase, jack_phase_next;
  logic [9:0]  jack_timer, jack_timer_next;
  logic        first_sample, first_sample_next;
  logic        stable_level, stable_level_next;
  logic [5:0]  poll_count, poll_count_next;
  logic [1:0]  kind_reg, kind_reg_next;
  logic        key_poll_on, key_poll_on_next;
  key_phase_t  key_phase, key_phase_next;
  logic [9:0]  key_timer, key_timer_next;
  logic        key_reg, key_reg_next;
  logic        jack_upd, key_upd;

  logic [ADC_W-1:0] adc_used;
  logic             adc_above;
  logic             do_classify;

  function automatic logic period_done(input logic [9:0] t, input logic [9:0] p);
    return ({1'b0, t} + 11'd1) >= {1'b0, p};
  endfunction

  function automatic logic key_hit(input logic bias, input logic lvl, input logic key_v,
                                   input logic above);
    return bias && !lvl && (key_v ? above : !above);
  endfunction

  assign adc_used  = ADC_W'(adc_level[USE_BITS-1:0]);
  assign adc_above = adc_used > key_threshold;

  always_comb begin
    jack_phase_next   = jack_phase;
    jack_timer_next   = jack_timer;
    first_sample_next = first_sample;
    stable_level_next = stable_level;
    poll_count_next   = poll_count;
    kind_reg_next     = kind_reg;
    key_poll_on_next  = key_poll_on;
    key_phase_next    = key_phase;
    key_timer_next    = key_timer;
    key_reg_next      = key_reg;
    jack_upd          = 1'b0;
    key_upd           = 1'b0;
    do_classify       = 1'b0;

    if (key_phase == KP_START) begin
      if (period_done(key_timer, key_start_delay)) begin
        key_timer_next = '0;
        key_phase_next = key_hit(mic_bias_on, jack_level, key_reg, adc_above) ?
                         KP_PENDING : KP_RUN;
      end else begin
        key_timer_next = key_timer + 10'd1;
      end
    end else if (key_phase == KP_PENDING || key_phase == KP_RUN) begin
      if (key_phase == KP_PENDING &&
          (period_done(key_timer, 10'(key_confirm_ticks)) ||
           period_done(key_timer, key_poll_interval))) begin
        if (!key_reg) begin
          if (!adc_above) begin
            key_reg_next = 1'b1;
            key_upd      = 1'b1;
          end
        end else if (mic_bias_on && adc_above) begin
          key_reg_next = 1'b0;
          key_upd      = 1'b1;
        end
        key_phase_next = KP_RUN;
      end
      if (period_done(key_timer, key_poll_interval)) begin
        key_timer_next = '0;
        key_phase_next = key_hit(mic_bias_on, jack_level, key_reg_next, adc_above) ?
                         KP_PENDING : KP_RUN;
      end else begin
        key_timer_next = key_timer + 10'd1;
      end
    end

    case (jack_phase)
      JP_WAIT: begin
        if (period_done(jack_timer, debounce_ticks)) begin
          jack_timer_next = '0;
          if (mic_bias_on) begin
            first_sample_next = jack_level;
            jack_phase_next   = JP_SETTLE;
          end
        end else begin
          jack_timer_next = jack_timer + 10'd1;
        end
      end
      JP_SETTLE: begin
        if (period_done(jack_timer, debounce_ticks)) begin
          jack_timer_next = '0;
          if (jack_level != first_sample) begin
            jack_phase_next = JP_IDLE;
          end else begin
            stable_level_next = jack_level;
            if (!jack_level) begin
              poll_count_next = '0;
              jack_phase_next = JP_CLASSIFY;
              do_classify     = 1'b1;
            end else begin
              key_poll_on_next = 1'b0;
              key_phase_next   = KP_IDLE;
              key_timer_next   = '0;
              if (key_reg_next) begin
                key_reg_next = 1'b0;
                key_upd      = 1'b1;
              end
              kind_reg_next   = KIND_NONE;
              jack_upd        = 1'b1;
              jack_phase_next = JP_IDLE;
            end
          end
        end else begin
          jack_timer_next = jack_timer + 10'd1;
        end
      end
      JP_CLASSIFY: begin
        if (period_done(jack_timer, 10'(classify_interval))) begin
          jack_timer_next = '0;
          do_classify     = 1'b1;
        end else begin
          jack_timer_next = jack_timer + 10'd1;
        end
      end
      default: begin
        jack_phase_next = JP_IDLE;
        if (jack_level != stable_level) begin
          jack_phase_next = JP_WAIT;
          jack_timer_next = '0;
        end
      end
    endcase

    if (do_classify) begin
      if (mic_bias_on && adc_above) begin
        kind_reg_next = KIND_HEADSET;
        if (!key_poll_on_next) begin
          key_poll_on_next = 1'b1;
          key_phase_next   = KP_START;
          key_timer_next   = '0;
        end
        jack_phase_next = JP_IDLE;
        jack_upd        = 1'b1;
      end else begin
        poll_count_next = poll_count_next + 6'd1;
        if (poll_count_next >= classify_polls) begin
          kind_reg_next   = KIND_HEADPHONE;
          jack_phase_next = JP_IDLE;
          jack_upd        = 1'b1;
        end
      end
    end
  end

  assign result = '{key_updated:  key_upd,
                    jack_updated: jack_upd,
                    key_down:     key_reg_next,
                    jack_kind:    kind_reg_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      key_threshold     <= 12'd5;
      debounce_ticks    <= 10'd100;
      classify_interval <= 8'd10;
      classify_polls    <= 6'd10;
      key_start_delay   <= 10'd200;
      key_poll_interval <= 10'd40;
      key_confirm_ticks <= 8'd5;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_KEY_THRESHOLD:     key_threshold     <= cfg_data;
        REG_DEBOUNCE_TICKS:    debounce_ticks    <= cfg_data[9:0];
        REG_CLASSIFY_INTERVAL: classify_interval <= cfg_data[7:0];
        REG_CLASSIFY_POLLS:    classify_polls    <= cfg_data[5:0];
        REG_KEY_START_DELAY:   key_start_delay   <= cfg_data[9:0];
        REG_KEY_POLL_INTERVAL: key_poll_interval <= cfg_data[9:0];
        REG_KEY_CONFIRM_TICKS: key_confirm_ticks <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      jack_phase   <= JP_WAIT;
      jack_timer   <= '0;
      first_sample <= 1'b0;
      stable_level <= 1'b1;
      poll_count   <= '0;
      kind_reg     <= KIND_NONE;
      key_poll_on  <= 1'b0;
      key_phase    <= KP_IDLE;
      key_timer    <= '0;
      key_reg      <= 1'b0;
    end else if (tick_valid) begin
      jack_phase   <= jack_phase_next;
      jack_timer   <= jack_timer_next;
      first_sample <= first_sample_next;
      stable_level <= stable_level_next;
      poll_count   <= poll_count_next;
      kind_reg     <= kind_reg_next;
      key_poll_on  <= key_poll_on_next;
      key_phase    <= key_phase_next;
      key_timer    <= key_timer_next;
      key_reg      <= key_reg_next;
    end
  end

endmodule

// File: hw/rtl/hjkd_out_buf.sv
// ----------------------------------------------------------------------------
// Headset jack and key detector output buffer
// Two-entry result queue so a new tick is taken while a result is stalled.
// ----------------------------------------------------------------------------
module hjkd_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  hjkd_pkg::result_t push_data,
  output logic              can_push,
  output logic              out_valid,
  input  logic              out_ready,
  output hjkd_pkg::result_t out_data
);
  import hjkd_pkg::*;

  result_t    entry0, entry1;
  logic [1:0] count;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = count != 2'd0;
  assign can_push  = count != 2'd2;
  assign out_data  = entry0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case ({push, pop})
        2'b11: begin
          if (count == 2'd1) begin
            entry0 <= push_data;
          end else begin
            entry0 <= entry1;
            entry1 <= push_data;
          end
        end
        2'b10: begin
          if (count == 2'd0) begin
            entry0 <= push_data;
          end else begin
            entry1 <= push_data;
          end
          count <= count + 2'd1;
        end
        2'b01: begin
          entry0 <= entry1;
          count  <= count - 2'd1;
        end
        default: ;
      endcase
    end
  end

endmodule

// File: hw/rtl/hjkd_checker.sv
// ----------------------------------------------------------------------------
// Headset jack and key detector checker
// Port-level properties of the detector, bound to the top level.
// ----------------------------------------------------------------------------
module hjkd_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);
  import hjkd_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("Result word present right after reset.");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[1:0] <= KIND_HEADPHONE)
    else $error("Illegal jack kind.");

  a_no_key_without_jack: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1:0] == KIND_NONE) |-> !m_tdata[2])
    else $error("Key reported down with no jack present.");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("Input stalled while no result is pending.");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("Stalled result word changed.");

endmodule

bind headset_jack_and_key_detector hjkd_checker u_hjkd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
